### hdl/slrg_pkg.sv
// ----------------------------------------------------------------------------
// slrg_pkg
// Shared constants and types for the shuffled Lehmer random generator.
// ----------------------------------------------------------------------------
`default_nettype none

package slrg_pkg;

  localparam int TABLE_DEPTH  = 32;
  localparam int WARMUP_STEPS = 8;

  localparam int VAL_W     = 31;
  localparam int MUL_W     = 15;
  localparam int IDX_W     = $clog2(TABLE_DEPTH);
  localparam int FILL_STEPS = TABLE_DEPTH + WARMUP_STEPS;
  localparam int CNT_W     = $clog2(FILL_STEPS);

  localparam logic [MUL_W-1:0] LEH_MUL    = MUL_W'(16807);
  localparam logic [VAL_W-1:0] LEH_MOD    = VAL_W'(2147483647);
  localparam logic [VAL_W-1:0] CEIL_LIMIT = VAL_W'(2147483389);

  typedef struct packed {
    logic             load_seed;
    logic             fill_step;
    logic             fill_wr;
    logic             fill_last;
    logic [IDX_W-1:0] fill_addr;
    logic             rd_en;
    logic             draw;
  } slrg_cmd_t;

  typedef struct packed {
    logic last_zero;
  } slrg_sts_t;

endpackage

`default_nettype wire

### hdl/shuffled_lehmer_random_generator.sv
// ----------------------------------------------------------------------------
// shuffled_lehmer_random_generator
// Lehmer generator (x16807 mod 2^31-1) behind a 32-entry shuffle table.
// ----------------------------------------------------------------------------
// One input word requests one draw and yields one result word. A normal draw
// reads the shuffle-table RAM at the index given by the top five bits of the
// previous output, then writes the fresh generator value to the same entry. A
// draw with restart set, or the first draw after reset, first reloads the
// generator from the seed register and runs TABLE_DEPTH + WARMUP_STEPS (40)
// generator steps, one per cycle, filling the table. One draw is in flight at
// a time; the next word is taken while the previous result still waits in the
// output register. The output integer over 2147483647 is the uniform fraction.
`default_nettype none

module shuffled_lehmer_random_generator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_restart,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [30:0]      out_random_value,
  output logic             out_at_ceiling,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  import slrg_pkg::*;

  localparam logic REG_SEED = 1'b0;

  logic [VAL_W-1:0] seed_r;
  slrg_cmd_t        cmd;
  slrg_sts_t        sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= VAL_W'(1);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == REG_SEED) begin
      seed_r <= cfg_pwdata[VAL_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_SEED) begin
      cfg_prdata = {1'b0, seed_r};
    end
  end

  assign cfg_pready = 1'b1;

  slrg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_restart (in_restart),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  slrg_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .seed         (seed_r),
    .sts          (sts),
    .random_value (out_random_value),
    .at_ceiling   (out_at_ceiling)
  );

  a_one_in_flight : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("word accepted while a draw is in progress");

  a_nonzero_value : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_random_value != '0)
    else $error("zero value delivered");

  a_ceiling_flag : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_at_ceiling == (out_random_value > CEIL_LIMIT))
    else $error("ceiling flag disagrees with value");

endmodule

`default_nettype wire

### hdl/slrg_ram.sv
// ----------------------------------------------------------------------------
// slrg_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module slrg_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 31
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hdl/slrg_dp.sv
// ----------------------------------------------------------------------------
// slrg_dp
// Datapath: Lehmer step unit, shuffle table, last-output and result words.
// ----------------------------------------------------------------------------
`default_nettype none

module slrg_dp (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire slrg_pkg::slrg_cmd_t     cmd,
  input  wire logic [slrg_pkg::VAL_W-1:0] seed,
  output slrg_pkg::slrg_sts_t          sts,
  output logic [slrg_pkg::VAL_W-1:0]   random_value,
  output logic                         at_ceiling
);

  import slrg_pkg::*;

  logic [VAL_W-1:0]       lehm_r;
  logic [VAL_W-1:0]       lehm_nxt;
  logic [VAL_W-1:0]       last_out_r;
  logic [VAL_W-1:0]       last_out_nxt;
  logic [VAL_W-1:0]       rv_r;
  logic                   ceil_r;
  logic [VAL_W+MUL_W-1:0] prod;
  logic [VAL_W:0]         fold;
  logic [VAL_W-1:0]       step_val;
  logic [VAL_W-1:0]       seed_fix;
  logic [IDX_W-1:0]       idx;
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  logic [VAL_W-1:0]       mem_rdata;

  always_comb begin
    prod = lehm_r * {{VAL_W{1'b0}}, LEH_MUL};
    fold = {1'b0, prod[VAL_W-1:0]} + {{(VAL_W+1-MUL_W){1'b0}}, prod[VAL_W+MUL_W-1:VAL_W]};
    if (fold >= {1'b0, LEH_MOD}) begin
      step_val = VAL_W'(fold - {1'b0, LEH_MOD});
    end else begin
      step_val = fold[VAL_W-1:0];
    end
  end

  always_comb begin
    if (seed == '0 || seed == LEH_MOD) begin
      seed_fix = VAL_W'(1);
    end else begin
      seed_fix = seed;
    end
  end

  assign idx = last_out_r[VAL_W-1 -: IDX_W];

  always_comb begin
    lehm_nxt     = lehm_r;
    last_out_nxt = last_out_r;
    if (cmd.load_seed) begin
      lehm_nxt = seed_fix;
    end else if (cmd.fill_step || cmd.draw) begin
      lehm_nxt = step_val;
    end
    if (cmd.fill_step && cmd.fill_last) begin
      last_out_nxt = step_val;
    end else if (cmd.draw) begin
      last_out_nxt = mem_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lehm_r     <= '0;
      last_out_r <= '0;
    end else begin
      lehm_r     <= lehm_nxt;
      last_out_r <= last_out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.draw) begin
      rv_r   <= mem_rdata;
      ceil_r <= (mem_rdata > CEIL_LIMIT);
    end
  end

  assign mem_we    = cmd.fill_wr || cmd.draw;
  assign mem_waddr = cmd.fill_step ? cmd.fill_addr : idx;

  slrg_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (VAL_W)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (step_val),
    .re    (cmd.rd_en),
    .raddr (idx),
    .rdata (mem_rdata)
  );

  assign sts.last_zero = (last_out_r == '0);
  assign random_value  = rv_r;
  assign at_ceiling    = ceil_r;

endmodule

`default_nettype wire

### hdl/slrg_ctrl.sv
// ----------------------------------------------------------------------------
// slrg_ctrl
// Controller: sequences table read and draw for each word, after a table fill on restart or first draw.
// ----------------------------------------------------------------------------
`default_nettype none

module slrg_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_restart,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire logic                out_stall,
  input  wire slrg_pkg::slrg_sts_t sts,
  output slrg_pkg::slrg_cmd_t      cmd
);

  import slrg_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FILL = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_DRAW = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovld_r, ovld_nxt;
  logic             in_acc;
  logic             out_free;

  assign in_acc   = in_valid && (state_r == ST_IDLE);
  assign out_free = !ovld_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    cmd.fill_addr = cnt_r[IDX_W-1:0];
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_restart || sts.last_zero) begin
            cmd.load_seed = 1'b1;
            cnt_nxt       = CNT_W'(FILL_STEPS - 1);
            state_nxt     = ST_FILL;
          end else begin
            cmd.rd_en = 1'b1;
            state_nxt = ST_DRAW;
          end
        end
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        cmd.fill_wr   = ({1'b0, cnt_r} < (CNT_W+1)'(TABLE_DEPTH));
        cmd.fill_last = (cnt_r == '0);
        if (cnt_r == '0) begin
          state_nxt = ST_READ;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_DRAW;
      end
      ST_DRAW: begin
        if (out_free) begin
          cmd.draw  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ovld_nxt = ovld_r;
    if (cmd.draw) begin
      ovld_nxt = 1'b1;
    end else if (!out_stall) begin
      ovld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = ovld_r;

endmodule

`default_nettype wire

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the shuffled Lehmer random generator.
// ----------------------------------------------------------------------------
// Each draw request word is mirrored by an in-bench model of the x16807
// mod 2^31-1 generator and its 32-entry shuffle table. The modelled result
// word is queued and compared field by field with each word taken from the
// output channel. Directed tests cover the first draw after reset, the seed
// corners (zero, 2^31-1, the largest legal seed, a set bit 31 on the bus)
// and seeds steered so that the first draw lands on the smallest value, on
// either side of the ceiling threshold and on the largest value. Random
// phases then vary the seed and the idling on both sides and set restart at
// random. One phase holds the receiver off long enough to back the block up.
// ----------------------------------------------------------------------------

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import slrg_pkg::*;

  localparam logic [2:0]      SEED_ADDR    = 3'd0;
  localparam int              CYCLE_LIMIT  = 1_000_000;
  localparam int              DRAIN_CYCLES = 60;
  localparam longint unsigned MODULUS      = longint'(LEH_MOD);
  localparam longint unsigned BUCKET       = 1 + (MODULUS - 1) / TABLE_DEPTH;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             at_ceiling;
  } draw_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_restart;
  logic        out_valid;
  logic        out_stall;
  logic [30:0] out_random_value;
  logic        out_at_ceiling;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  shuffled_lehmer_random_generator uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_restart       (in_restart),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_random_value (out_random_value),
    .out_at_ceiling   (out_at_ceiling),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Generator model state
  logic [VAL_W-1:0] gen_seed;
  logic [VAL_W-1:0] gen_state;
  logic [VAL_W-1:0] gen_last;
  logic [VAL_W-1:0] gen_table [TABLE_DEPTH];

  draw_t expected_draws[$];

  int src_idle_pct  = 0;
  int rcv_stall_pct = 0;
  int hold_left     = 0;
  int cycle_count   = 0;
  int errors        = 0;
  int draws_checked = 0;
  int ceiling_hits  = 0;
  int restarts_sent = 0;
  int seed_writes   = 0;

  function automatic logic [VAL_W-1:0] lehmer_step(logic [VAL_W-1:0] x);
    return VAL_W'((longint'(x) * longint'(LEH_MUL)) % MODULUS);
  endfunction

  function automatic longint unsigned mod_pow(longint unsigned b, longint unsigned e);
    longint unsigned r;
    longint unsigned p;
    longint unsigned k;
    r = 1;
    p = b % MODULUS;
    k = e;
    while (k != 0) begin
      if (k[0]) r = (r * p) % MODULUS;
      p = (p * p) % MODULUS;
      k = k >> 1;
    end
    return r;
  endfunction

  function automatic void refill_table();
    logic [VAL_W-1:0] s;
    s = gen_seed;
    if (s == '0 || s == LEH_MOD) s = VAL_W'(1);
    for (int j = FILL_STEPS - 1; j >= 0; j--) begin
      s = lehmer_step(s);
      if (j < TABLE_DEPTH) gen_table[j] = s;
    end
    gen_state = s;
    gen_last  = gen_table[0];
  endfunction

  function automatic draw_t predict_draw(logic restart_bit);
    int unsigned idx;
    draw_t       d;
    if (restart_bit || gen_last == '0) refill_table();
    gen_state = lehmer_step(gen_state);
    idx = int'((longint'(gen_last) / BUCKET) % TABLE_DEPTH);
    d.value = gen_table[idx];
    gen_table[idx] = gen_state;
    gen_last = d.value;
    d.at_ceiling = (d.value > CEIL_LIMIT);
    return d;
  endfunction

  // Solve for a seed whose first draw after a refill returns target; 0 if none.
  function automatic logic [VAL_W-1:0] seed_for_first_draw(logic [VAL_W-1:0] target);
    longint unsigned inv;
    longint unsigned last;
    logic [VAL_W-1:0] found;
    inv = mod_pow(longint'(LEH_MUL), MODULUS - 2);
    found = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      last = (longint'(target) * mod_pow(longint'(LEH_MUL), i)) % MODULUS;
      if (found == '0 && last / BUCKET == i)
        found = VAL_W'((longint'(target) * mod_pow(inv, FILL_STEPS - i)) % MODULUS);
    end
    return found;
  endfunction

  task automatic send_draw(logic restart_bit);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_restart = restart_bit;
    do @(posedge clk); while (in_stall);
    expected_draws.push_back(predict_draw(restart_bit));
    if (restart_bit) restarts_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_draws.size() != 0) @(posedge clk);
  endtask

  task automatic write_seed(logic [31:0] data);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = SEED_ADDR;
    cfg_pwdata  = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    gen_seed = data[VAL_W-1:0];
    seed_writes++;
    @(negedge clk);
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== {1'b0, data[VAL_W-1:0]}) begin
      $error("seed readback: expected %0d, actual %0d", data[VAL_W-1:0], cfg_prdata);
      errors++;
    end
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic test_first_draw_after_reset();
    src_idle_pct  = 0;
    rcv_stall_pct = 0;
    repeat (3) send_draw(1'b0);
    wait_drained();
  endtask

  task automatic test_seed_corners();
    logic [31:0] corners [4];
    corners = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h8000_0001};
    foreach (corners[i]) begin
      write_seed(corners[i]);
      send_draw(1'b1);
      send_draw(1'b0);
      wait_drained();
    end
  endtask

  task automatic test_output_extremes();
    logic [VAL_W-1:0] targets [4];
    int               steps [4];
    logic [VAL_W-1:0] s;
    targets = '{VAL_W'(1), CEIL_LIMIT, CEIL_LIMIT + VAL_W'(1), LEH_MOD - VAL_W'(1)};
    steps   = '{1, -1, 1, -1};
    foreach (targets[i]) begin
      s = '0;
      for (int k = 0; k < 200 && s == '0; k++)
        s = seed_for_first_draw(targets[i] + VAL_W'(steps[i] * k));
      if (s != '0) begin
        write_seed({1'b0, s});
        send_draw(1'b1);
        wait_drained();
      end
    end
  endtask

  task automatic test_random_draws(int count, int src_pct, int rcv_pct);
    int pick;
    src_idle_pct  = src_pct;
    rcv_stall_pct = rcv_pct;
    pick = $urandom_range(7);
    if (pick == 0)      write_seed(32'h0000_0000);
    else if (pick == 1) write_seed(32'h7FFF_FFFF);
    else                write_seed($urandom);
    repeat (count) send_draw($urandom_range(19) == 0);
    wait_drained();
  endtask

  task automatic test_backpressure();
    src_idle_pct  = 0;
    rcv_stall_pct = 0;
    write_seed($urandom);
    @(posedge clk);
    hold_left = 400;
    repeat (60) send_draw($urandom_range(9) == 0);
    wait_drained();
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(99) < rcv_stall_pct);
    end
  end

  always @(posedge clk) begin
    draw_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (expected_draws.size() == 0) begin
        $error("unexpected result word: random_value %0d", out_random_value);
        errors++;
      end else begin
        want = expected_draws.pop_front();
        if (out_random_value !== want.value) begin
          $error("random_value: expected %0d, actual %0d", want.value, out_random_value);
          errors++;
        end
        if (out_at_ceiling !== want.at_ceiling) begin
          $error("at_ceiling: expected %0d, actual %0d", want.at_ceiling, out_at_ceiling);
          errors++;
        end
        draws_checked++;
        if (want.at_ceiling) ceiling_hits++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_restart  = 1'b0;
    out_stall   = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    gen_seed    = VAL_W'(1);
    gen_state   = '0;
    gen_last    = '0;
    foreach (gen_table[i]) gen_table[i] = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_first_draw_after_reset();
    test_seed_corners();
    test_output_extremes();
    test_random_draws(500, 0, 0);
    test_random_draws(350, 86, 0);
    test_random_draws(350, 0, 86);
    test_random_draws(450, 37, 37);
    test_backpressure();
    test_random_draws(120, 86, 86);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d draws checked, %0d restarts, %0d seed writes, %0d at ceiling",
             draws_checked, restarts_sent, seed_writes, ceiling_hits);
    $display("summary: %0d mismatches in %0d cycles", errors, cycle_count);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/slrg_pkg.sv
hdl/slrg_ram.sv
hdl/slrg_dp.sv
hdl/slrg_ctrl.sv
hdl/shuffled_lehmer_random_generator.sv
bench/tb_top.sv
